FILE: rtl/core/bgd_pkg.sv
// shared types and constants of the button gesture detector
`timescale 1ns / 1ps
package bgd_pkg;

	localparam int MAX_BUTTONS = 8;
	localparam int THR_W       = 16;
	localparam int DT_W        = 16;
	localparam int CODE_W      = 4;
	localparam int IN_W        = DT_W + MAX_BUTTONS;
	localparam int GEST_W      = CODE_W * MAX_BUTTONS;
	localparam int OUT_W       = GEST_W + MAX_BUTTONS;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	typedef logic [CODE_W-1:0] phase_t;
	typedef logic [CODE_W-1:0] gesture_t;

	// phase codes
	localparam phase_t PH_REST      = 4'd0;
	localparam phase_t PH_DOWN1_DB  = 4'd1;
	localparam phase_t PH_DOWN1     = 4'd2;
	localparam phase_t PH_HOLD      = 4'd3;
	localparam phase_t PH_UP1_DB    = 4'd4;
	localparam phase_t PH_UP1       = 4'd5;
	localparam phase_t PH_PRESS1_DB = 4'd6;
	localparam phase_t PH_DOWN2_DB  = 4'd7;
	localparam phase_t PH_DOWN2     = 4'd8;
	localparam phase_t PH_UP2_DB    = 4'd9;
	localparam phase_t PH_PRESS2_DB = 4'd10;
	localparam phase_t PH_LAST_DB   = 4'd11;

	// gesture codes
	localparam gesture_t G_NONE       = 4'd0;
	localparam gesture_t G_DOWN       = 4'd1;
	localparam gesture_t G_UP         = 4'd2;
	localparam gesture_t G_CLICK      = 4'd3;
	localparam gesture_t G_DBL        = 4'd4;
	localparam gesture_t G_HOLD       = 4'd5;
	localparam gesture_t G_CLICKHOLD  = 4'd6;
	localparam gesture_t G_PRESS      = 4'd7;
	localparam gesture_t G_CLICKPRESS = 4'd8;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DBL      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REPORT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BTN_EN   = 3'd5;

	typedef struct packed {
		logic [THR_W-1:0] debounce;
		logic [THR_W-1:0] hold;
		logic [THR_W-1:0] press;
		logic [THR_W-1:0] dbl;
	} thr_t;

endpackage

FILE: rtl/core/bgd_lane.sv
// per-button phase machine with saturating timer
`timescale 1ns / 1ps
module bgd_lane #(
	parameter int TIME_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          tick,
	input  logic                          en,
	input  logic                          level,
	input  logic [bgd_pkg::DT_W-1:0]      dt,
	input  bgd_pkg::thr_t                 thr,
	output bgd_pkg::gesture_t             gesture
);

	localparam int CMP_W = (TIME_WIDTH > bgd_pkg::THR_W) ? TIME_WIDTH : bgd_pkg::THR_W;
	localparam int SUM_W = CMP_W + 1;
	localparam logic [SUM_W-1:0] TIMER_MAX = SUM_W'({TIME_WIDTH{1'b1}});

	bgd_pkg::phase_t       phase_q;
	logic [TIME_WIDTH-1:0] timer_q;
	bgd_pkg::phase_t       phase_n;
	logic [TIME_WIDTH-1:0] timer_n;
	bgd_pkg::gesture_t     gest_n;
	logic [SUM_W-1:0]      sum;
	logic [TIME_WIDTH-1:0] sat;
	logic [CMP_W-1:0]      sat_c;
	logic                  ge_db, ge_hold, ge_press, ge_dbl;

	always_comb begin
		sum   = SUM_W'(timer_q) + SUM_W'(dt);
		sat   = (sum > TIMER_MAX) ? {TIME_WIDTH{1'b1}} : sum[TIME_WIDTH-1:0];
		sat_c = CMP_W'(sat);
		ge_db    = sat_c >= CMP_W'(thr.debounce);
		ge_hold  = sat_c >= CMP_W'(thr.hold);
		ge_press = sat_c >= CMP_W'(thr.press);
		ge_dbl   = sat_c >= CMP_W'(thr.dbl);
	end

	always_comb begin
		phase_n = phase_q;
		timer_n = timer_q;
		gest_n  = bgd_pkg::G_NONE;
		unique case (phase_q) inside
			bgd_pkg::PH_DOWN1_DB, bgd_pkg::PH_DOWN2_DB: begin
				timer_n = sat;
				if (ge_db) begin
					if (level) begin
						gest_n  = bgd_pkg::G_DOWN;
						phase_n = (phase_q == bgd_pkg::PH_DOWN1_DB) ?
							bgd_pkg::PH_DOWN1 : bgd_pkg::PH_DOWN2;
						timer_n = '0;
					end else begin
						phase_n = bgd_pkg::PH_REST;
					end
				end
			end
			bgd_pkg::PH_DOWN1, bgd_pkg::PH_DOWN2: begin
				timer_n = sat;
				if (ge_hold) begin
					gest_n  = (phase_q == bgd_pkg::PH_DOWN1) ?
						bgd_pkg::G_HOLD : bgd_pkg::G_CLICKHOLD;
					phase_n = bgd_pkg::PH_HOLD;
				end else if (!level) begin
					if (!ge_press)
						phase_n = (phase_q == bgd_pkg::PH_DOWN1) ?
							bgd_pkg::PH_UP1_DB : bgd_pkg::PH_UP2_DB;
					else
						phase_n = (phase_q == bgd_pkg::PH_DOWN1) ?
							bgd_pkg::PH_PRESS1_DB : bgd_pkg::PH_PRESS2_DB;
					timer_n = '0;
				end
			end
			bgd_pkg::PH_HOLD: begin
				if (!level) begin
					phase_n = bgd_pkg::PH_LAST_DB;
					timer_n = '0;
				end
			end
			bgd_pkg::PH_UP1_DB: begin
				timer_n = sat;
				if (ge_db) begin
					if (!level) begin
						gest_n  = bgd_pkg::G_UP;
						phase_n = bgd_pkg::PH_UP1;
						timer_n = '0;
					end else begin
						phase_n = bgd_pkg::PH_REST;
					end
				end
			end
			bgd_pkg::PH_UP1: begin
				timer_n = sat;
				if (level) begin
					phase_n = bgd_pkg::PH_DOWN2_DB;
					timer_n = '0;
				end else if (ge_dbl) begin
					phase_n = bgd_pkg::PH_REST;
					gest_n  = bgd_pkg::G_CLICK;
				end
			end
			bgd_pkg::PH_PRESS1_DB, bgd_pkg::PH_UP2_DB, bgd_pkg::PH_PRESS2_DB: begin
				timer_n = sat;
				if (ge_db) begin
					if (!level) begin
						if (phase_q == bgd_pkg::PH_PRESS1_DB)
							gest_n = bgd_pkg::G_PRESS;
						else if (phase_q == bgd_pkg::PH_UP2_DB)
							gest_n = bgd_pkg::G_DBL;
						else
							gest_n = bgd_pkg::G_CLICKPRESS;
					end
					phase_n = bgd_pkg::PH_REST;
				end
			end
			bgd_pkg::PH_LAST_DB: begin
				timer_n = sat;
				if (ge_db && !level) begin
					gest_n  = bgd_pkg::G_UP;
					phase_n = bgd_pkg::PH_REST;
					timer_n = '0;
				end
			end
			default: begin
				// rest, and any code outside the machine
				if (level) begin
					phase_n = bgd_pkg::PH_DOWN1_DB;
					timer_n = '0;
				end else begin
					phase_n = bgd_pkg::PH_REST;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bgd_pkg::PH_REST;
			timer_q <= '0;
		end else if (tick) begin
			phase_q <= en ? phase_n : bgd_pkg::PH_REST;
			timer_q <= en ? timer_n : '0;
		end
	end

	assign gesture = en ? gest_n : bgd_pkg::G_NONE;

endmodule

FILE: rtl/core/bgd_merge.sv
// packs lane gestures into one result and buffers it in a two-entry output stage
`timescale 1ns / 1ps
module bgd_merge #(
	parameter int NUM_BUTTONS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         tick,
	input  logic                         report_en,
	input  bgd_pkg::gesture_t            lane_gest [NUM_BUTTONS],
	output logic                         s_tready,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [bgd_pkg::OUT_W-1:0]    m_tdata
);

	logic [bgd_pkg::GEST_W-1:0]      gest_pack;
	logic [bgd_pkg::MAX_BUTTONS-1:0] rel_pack;
	logic [bgd_pkg::OUT_W-1:0]       out_q, skid_q;
	logic                            out_valid_q, skid_valid_q;

	always_comb begin
		gest_pack = '0;
		rel_pack  = '0;
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			if (report_en) begin
				gest_pack[bgd_pkg::CODE_W*b +: bgd_pkg::CODE_W] = lane_gest[b];
				rel_pack[b] = (lane_gest[b] == bgd_pkg::G_PRESS) ||
					(lane_gest[b] == bgd_pkg::G_CLICKPRESS) ||
					(lane_gest[b] == bgd_pkg::G_DBL);
			end
		end
	end

	assign s_tready = !skid_valid_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q  <= skid_valid_q || tick;
			skid_valid_q <= 1'b0;
		end else if (tick) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (tick)
				out_q <= {rel_pack, gest_pack};
		end else if (tick) begin
			skid_q <= {rel_pack, gest_pack};
		end
	end

endmodule

FILE: rtl/core/button_gesture_detector_top.sv
// top level of the button gesture detector: config registers, button lanes, merge
// Usage:
//   s_* carries one tick per transfer: elapsed milliseconds and the button levels.
//   m_* carries one result per tick: a 4-bit gesture code per button and a
//   mask of gestures that also count as a release.
//   cfg_we/cfg_index/cfg_data write the thresholds, report enable and button
//   enable; write only while no tick is in flight.
// Output: a result is registered into the output buffer when its tick transfers.
// Throughput: one tick per cycle while s_tready is high; each button lane updates its phase and
//   saturating timer in the cycle of the transfer, so ticks run back to back.
// Stall: a two-entry output buffer absorbs one extra tick while m_tready is
//   low; s_tready drops only when both entries are full.
// Reset: all buttons return to rest with zero timers, the output buffer
//   empties, and the registers return to 20/1000/300/250 ms, reporting on,
//   all buttons enabled.
`timescale 1ns / 1ps
module button_gesture_detector_top #(
	parameter int NUM_BUTTONS = 8,
	parameter int TIME_WIDTH  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [bgd_pkg::IN_W-1:0]          s_tdata,   // elapsed_ms, button_levels
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [bgd_pkg::OUT_W-1:0]         m_tdata,   // gestures, also_release
	input  logic                              cfg_we,
	input  logic [bgd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bgd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	bgd_pkg::thr_t                   thr_q;
	logic                            report_en_q;
	logic [bgd_pkg::MAX_BUTTONS-1:0] btn_en_q;
	logic                            tick;
	logic [bgd_pkg::DT_W-1:0]        dt;
	logic [bgd_pkg::MAX_BUTTONS-1:0] levels;
	bgd_pkg::gesture_t               lane_gest [NUM_BUTTONS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.debounce <= 16'd20;
			thr_q.hold     <= 16'd1000;
			thr_q.press    <= 16'd300;
			thr_q.dbl      <= 16'd250;
			report_en_q    <= 1'b1;
			btn_en_q       <= 8'hFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bgd_pkg::CFG_DEBOUNCE: thr_q.debounce <= cfg_data;
				bgd_pkg::CFG_HOLD:     thr_q.hold     <= cfg_data;
				bgd_pkg::CFG_PRESS:    thr_q.press    <= cfg_data;
				bgd_pkg::CFG_DBL:      thr_q.dbl      <= cfg_data;
				bgd_pkg::CFG_REPORT:   report_en_q    <= cfg_data[0];
				bgd_pkg::CFG_BTN_EN:   btn_en_q       <= cfg_data[bgd_pkg::MAX_BUTTONS-1:0];
				default: ;
			endcase
		end
	end

	assign tick   = s_tvalid && s_tready;
	assign dt     = s_tdata[bgd_pkg::DT_W-1:0];
	assign levels = s_tdata[bgd_pkg::IN_W-1:bgd_pkg::DT_W];

	for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
		bgd_lane #(
			.TIME_WIDTH(TIME_WIDTH)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.tick    (tick),
			.en      (btn_en_q[b]),
			.level   (levels[b]),
			.dt      (dt),
			.thr     (thr_q),
			.gesture (lane_gest[b])
		);
	end

	bgd_merge #(
		.NUM_BUTTONS(NUM_BUTTONS)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick),
		.report_en (report_en_q),
		.lane_gest (lane_gest),
		.s_tready  (s_tready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

FILE: rtl/core/bgd_checker.sv
// port-level checks of the button gesture detector, bound to the top level
`timescale 1ns / 1ps
module bgd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [bgd_pkg::OUT_W-1:0]      m_tdata
);

	// held result stays put while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// input backpressure only when a result is waiting
	a_bp: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !$past(m_tready))
		else $error("input stalled with no pending result");

	for (genvar i = 0; i < bgd_pkg::MAX_BUTTONS; i++) begin : g_btn
		a_code: assert property (@(posedge clk) disable iff (!arst_n)
			m_tvalid |-> m_tdata[bgd_pkg::CODE_W*i +: bgd_pkg::CODE_W] <=
				bgd_pkg::G_CLICKPRESS)
			else $error("gesture code out of range");

		a_rel: assert property (@(posedge clk) disable iff (!arst_n)
			m_tvalid && m_tdata[bgd_pkg::GEST_W+i] |->
				m_tdata[bgd_pkg::CODE_W*i +: bgd_pkg::CODE_W] == bgd_pkg::G_DBL ||
				m_tdata[bgd_pkg::CODE_W*i +: bgd_pkg::CODE_W] == bgd_pkg::G_PRESS ||
				m_tdata[bgd_pkg::CODE_W*i +: bgd_pkg::CODE_W] == bgd_pkg::G_CLICKPRESS)
			else $error("release mask without a releasing gesture");
	end

endmodule

bind button_gesture_detector_top bgd_checker u_bgd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: sim/testbench.sv
// testbench for the button gesture detector: random press patterns checked against a predictor
`timescale 1ns / 1ps
module testbench;

	localparam int TIME_W = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 3;
	localparam logic [bgd_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [bgd_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	typedef struct {
		logic [bgd_pkg::GEST_W-1:0]      gestures;
		logic [bgd_pkg::MAX_BUTTONS-1:0] releases;
	} gesture_result_t;

	class gesture_checker;
		logic [bgd_pkg::THR_W-1:0]       debounce_ms = 16'd20;
		logic [bgd_pkg::THR_W-1:0]       hold_ms     = 16'd1000;
		logic [bgd_pkg::THR_W-1:0]       press_ms    = 16'd300;
		logic [bgd_pkg::THR_W-1:0]       dbl_ms      = 16'd250;
		logic                            report_on   = 1'b1;
		logic [bgd_pkg::MAX_BUTTONS-1:0] enabled     = 8'hFF;
		bgd_pkg::phase_t                 btn_phase [bgd_pkg::MAX_BUTTONS] =
			'{default: bgd_pkg::PH_REST};
		logic [TIME_W-1:0]               btn_timer [bgd_pkg::MAX_BUTTONS] = '{default: '0};
		gesture_result_t                 expected_gestures [$];
		int                              errors = 0;

		function void set_register(logic [bgd_pkg::CFG_IDX_W-1:0] idx,
			logic [bgd_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				bgd_pkg::CFG_DEBOUNCE: debounce_ms = data;
				bgd_pkg::CFG_HOLD:     hold_ms = data;
				bgd_pkg::CFG_PRESS:    press_ms = data;
				bgd_pkg::CFG_DBL:      dbl_ms = data;
				bgd_pkg::CFG_REPORT:   report_on = data[0];
				bgd_pkg::CFG_BTN_EN:   enabled = data[bgd_pkg::MAX_BUTTONS-1:0];
				default: ;
			endcase
		endfunction

		function logic [TIME_W-1:0] sat_add(logic [TIME_W-1:0] t, logic [bgd_pkg::DT_W-1:0] d);
			logic [TIME_W:0] s;
			s = {1'b0, t} + (TIME_W+1)'(d);
			return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
		endfunction

		function bgd_pkg::gesture_t advance_button(int b, bit high,
			logic [bgd_pkg::DT_W-1:0] dt);
			bgd_pkg::phase_t   ph;
			logic [TIME_W-1:0] t;
			bgd_pkg::gesture_t g;
			ph = btn_phase[b];
			t = btn_timer[b];
			g = bgd_pkg::G_NONE;
			case (ph)
				bgd_pkg::PH_DOWN1_DB, bgd_pkg::PH_DOWN2_DB: begin
					t = sat_add(t, dt);
					if (t >= debounce_ms) begin
						if (high) begin
							g = bgd_pkg::G_DOWN;
							ph = (ph == bgd_pkg::PH_DOWN1_DB) ?
								bgd_pkg::PH_DOWN1 : bgd_pkg::PH_DOWN2;
							t = '0;
						end else begin
							ph = bgd_pkg::PH_REST;
						end
					end
				end
				bgd_pkg::PH_DOWN1, bgd_pkg::PH_DOWN2: begin
					t = sat_add(t, dt);
					if (t >= hold_ms) begin
						g = (ph == bgd_pkg::PH_DOWN1) ? bgd_pkg::G_HOLD : bgd_pkg::G_CLICKHOLD;
						ph = bgd_pkg::PH_HOLD;
					end else if (!high) begin
						if (t < press_ms)
							ph = (ph == bgd_pkg::PH_DOWN1) ?
								bgd_pkg::PH_UP1_DB : bgd_pkg::PH_UP2_DB;
						else
							ph = (ph == bgd_pkg::PH_DOWN1) ?
								bgd_pkg::PH_PRESS1_DB : bgd_pkg::PH_PRESS2_DB;
						t = '0;
					end
				end
				bgd_pkg::PH_HOLD: begin
					if (!high) begin
						ph = bgd_pkg::PH_LAST_DB;
						t = '0;
					end
				end
				bgd_pkg::PH_UP1_DB: begin
					t = sat_add(t, dt);
					if (t >= debounce_ms) begin
						if (!high) begin
							g = bgd_pkg::G_UP;
							ph = bgd_pkg::PH_UP1;
							t = '0;
						end else begin
							ph = bgd_pkg::PH_REST;
						end
					end
				end
				bgd_pkg::PH_UP1: begin
					t = sat_add(t, dt);
					if (high) begin
						ph = bgd_pkg::PH_DOWN2_DB;
						t = '0;
					end else if (t >= dbl_ms) begin
						ph = bgd_pkg::PH_REST;
						g = bgd_pkg::G_CLICK;
					end
				end
				bgd_pkg::PH_PRESS1_DB, bgd_pkg::PH_UP2_DB, bgd_pkg::PH_PRESS2_DB: begin
					t = sat_add(t, dt);
					if (t >= debounce_ms) begin
						if (!high)
							g = (ph == bgd_pkg::PH_PRESS1_DB) ? bgd_pkg::G_PRESS :
							    (ph == bgd_pkg::PH_UP2_DB) ? bgd_pkg::G_DBL :
							    bgd_pkg::G_CLICKPRESS;
						ph = bgd_pkg::PH_REST;
					end
				end
				bgd_pkg::PH_LAST_DB: begin
					t = sat_add(t, dt);
					if (t >= debounce_ms && !high) begin
						g = bgd_pkg::G_UP;
						ph = bgd_pkg::PH_REST;
						t = '0;
					end
				end
				default: begin
					if (high) begin
						ph = bgd_pkg::PH_DOWN1_DB;
						t = '0;
					end else begin
						ph = bgd_pkg::PH_REST;
					end
				end
			endcase
			btn_phase[b] = ph;
			btn_timer[b] = t;
			return g;
		endfunction

		function void predict_tick(logic [bgd_pkg::DT_W-1:0] elapsed,
			logic [bgd_pkg::MAX_BUTTONS-1:0] levels);
			gesture_result_t   r;
			bgd_pkg::gesture_t g;
			r.gestures = '0;
			r.releases = '0;
			for (int b = 0; b < bgd_pkg::MAX_BUTTONS; b++) begin
				if (!enabled[b]) begin
					btn_phase[b] = bgd_pkg::PH_REST;
					btn_timer[b] = '0;
				end else begin
					g = advance_button(b, levels[b], elapsed);
					if (report_on && g != bgd_pkg::G_NONE) begin
						r.gestures[bgd_pkg::CODE_W*b +: bgd_pkg::CODE_W] = g;
						if (g == bgd_pkg::G_PRESS || g == bgd_pkg::G_CLICKPRESS ||
							g == bgd_pkg::G_DBL)
							r.releases[b] = 1'b1;
					end
				end
			end
			expected_gestures.push_back(r);
		endfunction

		function void check_result(logic [bgd_pkg::GEST_W-1:0] gestures,
			logic [bgd_pkg::MAX_BUTTONS-1:0] releases);
			gesture_result_t want;
			if (expected_gestures.size() == 0) begin
				$display("%0t unexpected transfer: gestures %h release %h",
					$time, gestures, releases);
				errors++;
				return;
			end
			want = expected_gestures.pop_front();
			if (gestures !== want.gestures) begin
				$display("%0t gestures mismatch: expected %h actual %h",
					$time, want.gestures, gestures);
				errors++;
			end
			if (releases !== want.releases) begin
				$display("%0t also_release mismatch: expected %h actual %h",
					$time, want.releases, releases);
				errors++;
			end
		endfunction

		function int pending();
			return expected_gestures.size();
		endfunction
	endclass

	localparam logic [bgd_pkg::IN_W-1:0] DIRECTED_TICKS [27] = '{
		{8'h00, 16'd0},     {8'hFF, 16'd0},     {8'hFF, 16'd20},    {8'h00, 16'd10},
		{8'h00, 16'd20},    {8'hFF, 16'd5},     {8'hFF, 16'd20},    {8'h0F, 16'd400},
		{8'h0F, 16'd20},    {8'h0F, 16'd65535}, {8'hF0, 16'd0},     {8'hF0, 16'd65535},
		{8'hF0, 16'd65535}, {8'h0F, 16'd0},     {8'h3F, 16'd30},    {8'h05, 16'd500},
		{8'h05, 16'd20},    {8'h00, 16'd0},     {8'h04, 16'd10},    {8'h04, 16'd10},
		{8'h80, 16'd0},     {8'h00, 16'd30},    {8'h01, 16'd0},     {8'h01, 16'd20},
		{8'h00, 16'd0},     {8'h00, 16'd20},    {8'h00, 16'd250}
	};

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [bgd_pkg::IN_W-1:0]       s_tdata   = '0;   // elapsed_ms, button_levels
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	logic [bgd_pkg::OUT_W-1:0]      m_tdata;          // gestures, also_release
	logic                           cfg_we    = 1'b0;
	logic [bgd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [bgd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	gesture_checker sb;
	int  gap_pct   = 0;
	int  stall_pct = 0;
	int  step_max  = 3;
	int  cycle_count = 0;
	bit  btn_level [bgd_pkg::MAX_BUTTONS];
	int  btn_left  [bgd_pkg::MAX_BUTTONS];

	button_gesture_detector_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata[bgd_pkg::GEST_W-1:0],
				m_tdata[bgd_pkg::OUT_W-1:bgd_pkg::GEST_W]);
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_tick(input logic [bgd_pkg::DT_W-1:0] elapsed,
		input logic [bgd_pkg::MAX_BUTTONS-1:0] levels);
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {levels, elapsed};
		do
			@(posedge clk);
		while (!s_tready);
		sb.predict_tick(elapsed, levels);
		@(negedge clk);
	endtask

	task automatic wait_drained(input int extra);
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	task automatic write_register(input logic [bgd_pkg::CFG_IDX_W-1:0] idx,
		input logic [bgd_pkg::CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.set_register(idx, data);
		@(negedge clk);
	endtask

	task automatic write_thresholds(input int deb, input int hold, input int press, input int dbl);
		write_register(bgd_pkg::CFG_DEBOUNCE, bgd_pkg::CFG_DATA_W'(deb));
		write_register(bgd_pkg::CFG_HOLD, bgd_pkg::CFG_DATA_W'(hold));
		write_register(bgd_pkg::CFG_PRESS, bgd_pkg::CFG_DATA_W'(press));
		write_register(bgd_pkg::CFG_DBL, bgd_pkg::CFG_DATA_W'(dbl));
	endtask

	task automatic apply_settings(input int phase_no);
		case (phase_no)
			1: begin
				write_thresholds(0, 0, 0, 0);
				write_register(bgd_pkg::CFG_REPORT, 16'h0001);
				write_register(bgd_pkg::CFG_BTN_EN, 16'h00FF);
			end
			2: begin
				write_thresholds(65535, 65535, 65535, 65535);
				write_register(bgd_pkg::CFG_REPORT, 16'hFFFF);
				write_register(bgd_pkg::CFG_BTN_EN, 16'hFFFF);
			end
			3: begin
				write_thresholds(20, 1000, 300, 250);
				write_register(bgd_pkg::CFG_REPORT,
					bgd_pkg::CFG_DATA_W'({$urandom_range(32767), 1'b0}));
			end
			4: begin
				write_thresholds(5, 200, 60, 80);
				write_register(bgd_pkg::CFG_REPORT,
					bgd_pkg::CFG_DATA_W'({$urandom_range(32767), 1'b1}));
				write_register(bgd_pkg::CFG_BTN_EN, bgd_pkg::CFG_DATA_W'($urandom));
				write_register(CFG_SPARE_LO, bgd_pkg::CFG_DATA_W'($urandom));
				write_register(CFG_SPARE_HI, bgd_pkg::CFG_DATA_W'($urandom));
			end
			5: begin
				write_register(bgd_pkg::CFG_BTN_EN,
					bgd_pkg::CFG_DATA_W'($urandom) & 16'hFF00);
			end
			6: begin
				write_thresholds($urandom_range(30), $urandom_range(600, 50),
					$urandom_range(200, 10), $urandom_range(200, 10));
				write_register(bgd_pkg::CFG_BTN_EN, 16'h00FF);
			end
			default: begin
				write_thresholds($urandom, $urandom, $urandom, $urandom);
				write_register(bgd_pkg::CFG_BTN_EN, bgd_pkg::CFG_DATA_W'($urandom));
			end
		endcase
		cfg_we <= 1'b0;
	endtask

	function automatic int rand_between(input int lo, input int hi);
		return $urandom_range(hi, lo);
	endfunction

	// how long a button stays at its new level, in ms, sized to the thresholds
	function automatic int pick_duration(input bit pressed);
		int deb;
		int hold;
		int press;
		int dbl;
		deb = int'(sb.debounce_ms);
		hold = int'(sb.hold_ms);
		press = int'(sb.press_ms);
		dbl = int'(sb.dbl_ms);
		if (pressed) begin
			case ($urandom_range(3))
				0: return rand_between(0, deb);
				1: return rand_between(deb, deb + press);
				2: return rand_between(deb + press, deb + hold);
				default: return rand_between(deb + hold, deb + hold + hold / 2 + step_max);
			endcase
		end
		case ($urandom_range(2))
			0: return rand_between(0, deb);
			1: return rand_between(deb, deb + dbl);
			default: return rand_between(deb + dbl, deb + 2 * dbl + step_max);
		endcase
	endfunction

	task automatic start_patterns();
		int m;
		m = int'(sb.debounce_ms);
		if (int'(sb.hold_ms) > m) m = int'(sb.hold_ms);
		if (int'(sb.press_ms) > m) m = int'(sb.press_ms);
		if (int'(sb.dbl_ms) > m) m = int'(sb.dbl_ms);
		step_max = m / 6 + 3;
		for (int b = 0; b < bgd_pkg::MAX_BUTTONS; b++) begin
			btn_level[b] = 1'b0;
			btn_left[b] = pick_duration(1'b0);
		end
	endtask

	task automatic make_tick(output logic [bgd_pkg::DT_W-1:0] elapsed,
		output logic [bgd_pkg::MAX_BUTTONS-1:0] levels);
		if ($urandom_range(19) == 0)
			elapsed = bgd_pkg::DT_W'($urandom);
		else
			elapsed = bgd_pkg::DT_W'($urandom_range(step_max));
		for (int b = 0; b < bgd_pkg::MAX_BUTTONS; b++) begin
			btn_left[b] -= int'(elapsed);
			if (btn_left[b] <= 0) begin
				btn_level[b] = !btn_level[b];
				btn_left[b] = pick_duration(btn_level[b]);
			end
			levels[b] = btn_level[b];
		end
		// occasional glitches break the patterns
		if ($urandom_range(9) == 0)
			levels ^= bgd_pkg::MAX_BUTTONS'($urandom);
	endtask

	task automatic run_patterns(input int count);
		logic [bgd_pkg::DT_W-1:0]        elapsed;
		logic [bgd_pkg::MAX_BUTTONS-1:0] levels;
		start_patterns();
		for (int i = 0; i < count; i++) begin
			if (i == count / 2)
				wait_drained(0);
			make_tick(elapsed, levels);
			send_tick(elapsed, levels);
		end
	endtask

	initial begin
		sb = new;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int p = 0; p < 8; p++) begin
			if (p != 0) begin
				wait_drained(SETTLE_CYCLES);
				apply_settings(p);
			end
			case (p % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 55; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 55; end
				default: begin gap_pct = 6; stall_pct = 6; end
			endcase
			if (p == 0)
				foreach (DIRECTED_TICKS[i])
					send_tick(DIRECTED_TICKS[i][bgd_pkg::DT_W-1:0],
						DIRECTED_TICKS[i][bgd_pkg::IN_W-1:bgd_pkg::DT_W]);
			run_patterns(p == 5 ? 30 : 48);
		end
		wait_drained(SETTLE_CYCLES);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/bgd_pkg.sv
rtl/core/bgd_lane.sv
rtl/core/bgd_merge.sv
rtl/core/button_gesture_detector_top.sv
rtl/core/bgd_checker.sv
sim/testbench.sv
